>>> rtl/dstt_pkg.sv
// Shared types for the deadline sorted timer table.
// Holds command and status codes and the controller/datapath interface structs.
`timescale 1ns / 1ps

package dstt_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_RESET  = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_FIRED     = 3'd3,
    ST_SUMMARY   = 3'd4
  } status_e;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_IDX_ZERO,
    OP_FIND_STEP,
    OP_CAP_POS,
    OP_CAP_HEAD,
    OP_DROP_STEP,
    OP_DROP_END,
    OP_INS_START,
    OP_INS_STEP,
    OP_INS_END,
    OP_TICK,
    OP_SCAN_STEP,
    OP_SCAN_END,
    OP_NEXT,
    OP_EMIT
  } op_e;

  // Slot read address select
  typedef enum logic [1:0] {
    RD_IDX,
    RD_PREV,
    RD_NEXT
  } rd_sel_e;

  typedef struct packed {
    op_e     op;
    rd_sel_e rd_sel;
    status_e emit_status;
  } ctl_t;

  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic find_end;
    logic id_match;
    logic drop_more;
    logic ins_move;
    logic scan_hit;
    logic due_zero;
    logic last_fire;
    logic t_rep;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/dstt_dp.sv
// Datapath of the timer table: slot storage, time counter, walk index and
// output word register. Uses dstt_pkg; driven by dstt_ctrl.
`timescale 1ns / 1ps

module dstt_dp import dstt_pkg::*; #(
  parameter int MAX_TIMERS    = 16,
  parameter int ID_BITS       = 16,
  parameter int DURATION_BITS = 24,
  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1,
  localparam int CW = $clog2(MAX_TIMERS + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctl_t                     ctl_i,
  output sts_t                     sts_o,
  input  logic [1:0]               command_i,
  input  logic [ID_BITS-1:0]       timer_id_i,
  input  logic [DURATION_BITS-1:0] duration_i,
  input  logic                     repeat_req_i,
  input  logic                     new_duration_flag_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [ID_BITS-1:0]       timer_id_res_o,
  output logic [CW-1:0]            fired_count_o,
  output logic [CW-1:0]            occupancy_o,
  output logic                     last_o
);

  // Slot storage, no reset: only entries below the held count are read
  logic [31:0]              dl_q  [MAX_TIMERS];
  logic [DURATION_BITS-1:0] per_q [MAX_TIMERS];
  logic [ID_BITS-1:0]       id_q  [MAX_TIMERS];
  logic                     rep_q [MAX_TIMERS];

  logic [31:0]              time_q;
  logic [CW-1:0]            held_q, idx_q, due_q, one_q, n_q, occ_fin_q;
  cmd_e                     cmd_q;
  logic [ID_BITS-1:0]       lat_id_q, t_id_q;
  logic [DURATION_BITS-1:0] lat_dur_q, t_per_q;
  logic                     lat_newdur_q, t_rep_q;
  logic [31:0]              when_q;

  logic                     out_valid_q;
  logic [2:0]               status_q;
  logic [ID_BITS-1:0]       res_id_q;
  logic [CW-1:0]            fired_q, occ_q;
  logic                     last_q;

  logic [CW-1:0]            rd_cnt;
  logic [IW-1:0]            rd_addr, wr_addr;
  logic [31:0]              rd_dl, ins_diff, due_diff;
  logic [DURATION_BITS-1:0] rd_per;
  logic [ID_BITS-1:0]       rd_id;
  logic                     rd_rep;
  logic                     wr_en;
  logic [31:0]              wr_dl;
  logic [DURATION_BITS-1:0] wr_per;
  logic [ID_BITS-1:0]       wr_id;
  logic                     wr_rep;
  logic                     out_free;

  // Select the single slot read address
  always_comb begin
    unique case (ctl_i.rd_sel)
      RD_PREV: rd_cnt = idx_q - CW'(1);
      RD_NEXT: rd_cnt = idx_q + CW'(1);
      default: rd_cnt = idx_q;
    endcase
  end
  assign rd_addr = rd_cnt[IW-1:0];
  assign rd_dl   = dl_q[rd_addr];
  assign rd_per  = per_q[rd_addr];
  assign rd_id   = id_q[rd_addr];
  assign rd_rep  = rep_q[rd_addr];

  assign ins_diff = rd_dl - when_q;
  assign due_diff = rd_dl - time_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // Status toward the controller
  always_comb begin
    sts_o.cmd       = cmd_q;
    sts_o.full      = (held_q == CW'(MAX_TIMERS));
    sts_o.find_end  = (idx_q >= held_q);
    sts_o.id_match  = (rd_id == lat_id_q);
    sts_o.drop_more = ((idx_q + CW'(1)) < held_q);
    sts_o.ins_move  = (idx_q != '0) && (ins_diff != 32'd0) && !ins_diff[31];
    sts_o.scan_hit  = (idx_q < held_q) && ((due_diff == 32'd0) || due_diff[31]);
    sts_o.due_zero  = (due_q == '0);
    sts_o.last_fire = (n_q == CW'(1));
    sts_o.t_rep     = t_rep_q;
    sts_o.out_free  = out_free;
  end

  // Slot write port: shift one entry or place the new one
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q[IW-1:0];
    wr_dl   = rd_dl;
    wr_per  = rd_per;
    wr_id   = rd_id;
    wr_rep  = rd_rep;
    unique case (ctl_i.op)
      OP_INS_STEP, OP_DROP_STEP: wr_en = 1'b1;
      OP_INS_END: begin
        wr_en  = 1'b1;
        wr_dl  = when_q;
        wr_per = t_per_q;
        wr_id  = t_id_q;
        wr_rep = t_rep_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dl_q[wr_addr]  <= wr_dl;
      per_q[wr_addr] <= wr_per;
      id_q[wr_addr]  <= wr_id;
      rep_q[wr_addr] <= wr_rep;
    end
  end

  // Control state: time, held count and walk counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q    <= '0;
      held_q    <= '0;
      idx_q     <= '0;
      due_q     <= '0;
      one_q     <= '0;
      n_q       <= '0;
      occ_fin_q <= '0;
      cmd_q     <= CMD_ADD;
    end else begin
      unique case (ctl_i.op)
        OP_LOAD:      cmd_q <= cmd_e'(command_i);
        OP_IDX_ZERO:  idx_q <= '0;
        OP_FIND_STEP: idx_q <= idx_q + CW'(1);
        OP_DROP_STEP: idx_q <= idx_q + CW'(1);
        OP_DROP_END:  held_q <= held_q - CW'(1);
        OP_INS_START: idx_q <= held_q;
        OP_INS_STEP:  idx_q <= idx_q - CW'(1);
        OP_INS_END:   held_q <= held_q + CW'(1);
        OP_TICK: begin
          time_q <= time_q + 32'd1;
          idx_q  <= '0;
          due_q  <= '0;
          one_q  <= '0;
        end
        OP_SCAN_STEP: begin
          idx_q <= idx_q + CW'(1);
          due_q <= due_q + CW'(1);
          one_q <= one_q + CW'(!rd_rep);
        end
        OP_SCAN_END: begin
          n_q       <= due_q;
          occ_fin_q <= held_q - one_q;
          idx_q     <= '0;
        end
        OP_NEXT: begin
          n_q   <= n_q - CW'(1);
          idx_q <= '0;
        end
        default: idx_q <= idx_q;
      endcase
    end
  end

  // Payload registers of the current command and the timer in flight
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      OP_LOAD: begin
        lat_id_q     <= timer_id_i;
        lat_dur_q    <= duration_i;
        lat_newdur_q <= new_duration_flag_i;
        t_id_q       <= timer_id_i;
        t_per_q      <= duration_i;
        t_rep_q      <= repeat_req_i;
      end
      OP_CAP_POS: begin
        t_per_q <= lat_newdur_q ? lat_dur_q : rd_per;
        t_rep_q <= rd_rep;
      end
      OP_CAP_HEAD: begin
        t_id_q  <= rd_id;
        t_per_q <= rd_per;
        t_rep_q <= rd_rep;
      end
      OP_INS_START: when_q <= time_q + 32'(t_per_q);
      default: when_q <= when_q;
    endcase
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_EMIT) begin
      status_q <= ctl_i.emit_status;
      unique case (ctl_i.emit_status)
        ST_FIRED: begin
          res_id_q <= t_id_q;
          fired_q  <= '0;
          occ_q    <= occ_fin_q;
          last_q   <= 1'b0;
        end
        ST_SUMMARY: begin
          res_id_q <= '0;
          fired_q  <= due_q;
          occ_q    <= held_q;
          last_q   <= 1'b1;
        end
        default: begin
          res_id_q <= lat_id_q;
          fired_q  <= '0;
          occ_q    <= held_q;
          last_q   <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign timer_id_res_o = res_id_q;
  assign fired_count_o  = fired_q;
  assign occupancy_o    = occ_q;
  assign last_o         = last_q;

endmodule

>>> rtl/dstt_ctrl.sv
// Controller of the timer table: sequences find, drop, insert and tick walks.
// Uses dstt_pkg; issues one datapath operation per cycle to dstt_dp.
`timescale 1ns / 1ps

module dstt_ctrl import dstt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_FIND      = 4'd2;
  localparam logic [3:0] S_DROP      = 4'd3;
  localparam logic [3:0] S_INS_PRE   = 4'd4;
  localparam logic [3:0] S_INS       = 4'd5;
  localparam logic [3:0] S_SCAN      = 4'd6;
  localparam logic [3:0] S_FIRE_CAP  = 4'd7;
  localparam logic [3:0] S_FIRE_EMIT = 4'd8;
  localparam logic [3:0] S_NEXT      = 4'd9;
  localparam logic [3:0] S_RESP      = 4'd10;

  logic [3:0] state_q, state_d;
  status_e    resp_q, resp_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and datapath operation
  always_comb begin
    state_d           = state_q;
    resp_d            = resp_q;
    ctl_o.op          = OP_NONE;
    ctl_o.rd_sel      = RD_IDX;
    ctl_o.emit_status = resp_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.cmd)
          CMD_ADD: begin
            if (sts_i.full) begin
              resp_d  = ST_FULL;
              state_d = S_RESP;
            end else begin
              ctl_o.op = OP_INS_START;
              state_d  = S_INS;
            end
          end
          CMD_TICK: begin
            ctl_o.op = OP_TICK;
            state_d  = S_SCAN;
          end
          default: begin
            ctl_o.op = OP_IDX_ZERO;
            state_d  = S_FIND;
          end
        endcase
      end
      S_FIND: begin
        if (sts_i.find_end) begin
          resp_d  = ST_NOT_FOUND;
          state_d = S_RESP;
        end else if (sts_i.id_match) begin
          ctl_o.op = (sts_i.cmd == CMD_RESET) ? OP_CAP_POS : OP_NONE;
          state_d  = S_DROP;
        end else begin
          ctl_o.op = OP_FIND_STEP;
        end
      end
      S_DROP: begin
        ctl_o.rd_sel = RD_NEXT;
        if (sts_i.drop_more) begin
          ctl_o.op = OP_DROP_STEP;
        end else begin
          ctl_o.op = OP_DROP_END;
          priority if (sts_i.cmd == CMD_RESET) begin
            state_d = S_INS_PRE;
          end else if (sts_i.cmd == CMD_TICK) begin
            state_d = sts_i.t_rep ? S_INS_PRE : S_NEXT;
          end else begin
            resp_d  = ST_DONE;
            state_d = S_RESP;
          end
        end
      end
      S_INS_PRE: begin
        ctl_o.op = OP_INS_START;
        state_d  = S_INS;
      end
      S_INS: begin
        ctl_o.rd_sel = RD_PREV;
        if (sts_i.ins_move) begin
          ctl_o.op = OP_INS_STEP;
        end else begin
          ctl_o.op = OP_INS_END;
          if (sts_i.cmd == CMD_TICK) begin
            state_d = S_NEXT;
          end else begin
            resp_d  = ST_DONE;
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.scan_hit) begin
          ctl_o.op = OP_SCAN_STEP;
        end else begin
          ctl_o.op = OP_SCAN_END;
          if (sts_i.due_zero) begin
            resp_d  = ST_SUMMARY;
            state_d = S_RESP;
          end else begin
            state_d = S_FIRE_CAP;
          end
        end
      end
      S_FIRE_CAP: begin
        ctl_o.op = OP_CAP_HEAD;
        state_d  = S_FIRE_EMIT;
      end
      S_FIRE_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.op          = OP_EMIT;
          ctl_o.emit_status = ST_FIRED;
          state_d           = S_DROP;
        end
      end
      S_NEXT: begin
        ctl_o.op = OP_NEXT;
        if (sts_i.last_fire) begin
          resp_d  = ST_SUMMARY;
          state_d = S_RESP;
        end else begin
          state_d = S_FIRE_CAP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          ctl_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= ST_DONE;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

endmodule

>>> rtl/deadline_sorted_timer_table_core.sv
// Deadline sorted timer table: keeps up to MAX_TIMERS timers in deadline order
// (ties in insertion order) and answers add, remove, reset and tick commands.
// One command is worked at a time; the input stalls until its last result word
// is written to the output register. All walks go through the slot table one
// entry per cycle over a single read port. Time wraps modulo 2^32 and deadlines
// compare by signed difference. Uses dstt_pkg, dstt_ctrl and dstt_dp.
`timescale 1ns / 1ps

module deadline_sorted_timer_table_core import dstt_pkg::*; #(
  parameter int MAX_TIMERS    = 16,
  parameter int ID_BITS       = 16,
  parameter int DURATION_BITS = 24,
  localparam int CW = $clog2(MAX_TIMERS + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               command_i,
  input  logic [ID_BITS-1:0]       timer_id_i,
  input  logic [DURATION_BITS-1:0] duration_i,
  input  logic                     repeat_req_i,
  input  logic                     new_duration_flag_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [ID_BITS-1:0]       timer_id_res_o,
  output logic [CW-1:0]            fired_count_o,
  output logic [CW-1:0]            occupancy_o,
  output logic                     last_o
);

  ctl_t ctl;
  sts_t sts;

  // Sequence the walks
  dstt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Hold slots, time and the output word
  dstt_dp #(
    .MAX_TIMERS    (MAX_TIMERS),
    .ID_BITS       (ID_BITS),
    .DURATION_BITS (DURATION_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctl_i               (ctl),
    .sts_o               (sts),
    .command_i           (command_i),
    .timer_id_i          (timer_id_i),
    .duration_i          (duration_i),
    .repeat_req_i        (repeat_req_i),
    .new_duration_flag_i (new_duration_flag_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .timer_id_res_o      (timer_id_res_o),
    .fired_count_o       (fired_count_o),
    .occupancy_o         (occupancy_o),
    .last_o              (last_o)
  );

endmodule

>>> tb/dstt_checker.sv
// Result checker for the deadline sorted timer table.
// Watches the command and result channels, predicts results, compares them.
// Depends on dstt_pkg.
`timescale 1ns / 1ps

module dstt_checker import dstt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  command_i,
  input  logic [15:0] timer_id_i,
  input  logic [23:0] duration_i,
  input  logic        repeat_req_i,
  input  logic        new_duration_flag_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [15:0] timer_id_res_i,
  input  logic [4:0]  fired_count_i,
  input  logic [4:0]  occupancy_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int SLOTS = 16;

  typedef struct packed {
    status_e     status;
    logic [15:0] id;
    logic [4:0]  fired;
    logic [4:0]  occ;
    logic        last;
  } result_word_t;

  result_word_t expected_words[$];

  logic [31:0] now_q;
  logic [31:0] due_at[SLOTS];
  logic [23:0] period_of[SLOTS];
  logic [15:0] id_of[SLOTS];
  logic        rep_of[SLOTS];
  int          held;

  task automatic report_mismatch(input string what);
    $display("MISMATCH t=%0t %s", $time, what);
    fail_count_o++;
  endtask

  function automatic void remove_slot(input int pos);
    for (int i = pos; i + 1 < held; i++) begin
      due_at[i] = due_at[i+1];
      period_of[i] = period_of[i+1];
      id_of[i] = id_of[i+1];
      rep_of[i] = rep_of[i+1];
    end
    held--;
  endfunction

  // Insert behind every entry whose deadline is not later
  function automatic void arm_timer(input logic [15:0] id, input logic [23:0] per,
                                    input logic rep);
    logic [31:0] w;
    logic [31:0] d;
    int pos;
    w = now_q + 32'(per);
    pos = 0;
    while (pos < held) begin
      d = due_at[pos] - w;
      if (d != 0 && !d[31]) break;
      pos++;
    end
    for (int i = held; i > pos; i--) begin
      due_at[i] = due_at[i-1];
      period_of[i] = period_of[i-1];
      id_of[i] = id_of[i-1];
      rep_of[i] = rep_of[i-1];
    end
    due_at[pos] = w;
    period_of[pos] = per;
    id_of[pos] = id;
    rep_of[pos] = rep;
    held++;
  endfunction

  function automatic void push_word(input status_e st, input logic [15:0] id,
                                    input int fired, input logic last);
    result_word_t r;
    r.status = st;
    r.id = id;
    r.fired = 5'(fired);
    r.occ = 5'(held);
    r.last = last;
    expected_words.push_back(r);
  endfunction

  // Work out the results of one accepted command word
  function automatic void predict_command(input cmd_e cmd, input logic [15:0] id,
                                          input logic [23:0] dur, input logic rep,
                                          input logic newdur);
    int pos;
    int due;
    logic [15:0] fired_ids[SLOTS];
    logic [31:0] d;
    logic [15:0] hid;
    logic [23:0] hper;
    logic hrep;
    case (cmd)
      CMD_ADD: begin
        if (held >= SLOTS) push_word(ST_FULL, id, 0, 1'b1);
        else begin
          arm_timer(id, dur, rep);
          push_word(ST_DONE, id, 0, 1'b1);
        end
      end
      CMD_REMOVE, CMD_RESET: begin
        pos = -1;
        for (int i = 0; i < held; i++)
          if (pos < 0 && id_of[i] == id) pos = i;
        if (pos < 0) push_word(ST_NOT_FOUND, id, 0, 1'b1);
        else begin
          hper = newdur ? dur : period_of[pos];
          hrep = rep_of[pos];
          remove_slot(pos);
          if (cmd == CMD_RESET) arm_timer(id, hper, hrep);
          push_word(ST_DONE, id, 0, 1'b1);
        end
      end
      default: begin
        now_q++;
        due = 0;
        while (due < held) begin
          d = due_at[due] - now_q;
          if (!(d == 0 || d[31])) break;
          due++;
        end
        for (int n = 0; n < due; n++) begin
          hid = id_of[0];
          hper = period_of[0];
          hrep = rep_of[0];
          fired_ids[n] = hid;
          remove_slot(0);
          if (hrep) arm_timer(hid, hper, 1'b1);
        end
        for (int n = 0; n < due; n++) push_word(ST_FIRED, fired_ids[n], 0, 1'b0);
        push_word(ST_SUMMARY, 16'd0, due, 1'b1);
      end
    endcase
  endfunction

  // Predict on accepted commands, compare accepted result words
  always @(posedge clk_i or negedge rst_ni) begin
    result_word_t exp_w;
    if (!rst_ni) begin
      now_q = '0;
      held = 0;
      fail_count_o = 0;
      expected_words.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        predict_command(cmd_e'(command_i), timer_id_i, duration_i, repeat_req_i,
                        new_duration_flag_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) report_mismatch("result word with none expected");
        else begin
          exp_w = expected_words.pop_front();
          if (status_i !== exp_w.status)
            report_mismatch($sformatf("status %0d exp %0d", status_i, exp_w.status));
          if (timer_id_res_i !== exp_w.id)
            report_mismatch($sformatf("id %0h exp %0h", timer_id_res_i, exp_w.id));
          if (fired_count_i !== exp_w.fired)
            report_mismatch($sformatf("fired %0d exp %0d", fired_count_i, exp_w.fired));
          if (occupancy_i !== exp_w.occ)
            report_mismatch($sformatf("occupancy %0d exp %0d", occupancy_i, exp_w.occ));
          if (last_i !== exp_w.last)
            report_mismatch($sformatf("last %0b exp %0b", last_i, exp_w.last));
        end
      end
    end
    pending_o = expected_words.size();
  end

endmodule

>>> tb/deadline_sorted_timer_table_core_tb.sv
// Testbench top for the deadline sorted timer table core.
// Drives commands with random idling and back pressure; dstt_checker checks.
// Depends on dstt_pkg, dstt_checker and the core RTL.
`timescale 1ns / 1ps

module deadline_sorted_timer_table_core_tb import dstt_pkg::*;;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = '0;
  logic [15:0] timer_id_i = '0;
  logic [23:0] duration_i = '0;
  logic        repeat_req_i = 1'b0;
  logic        new_duration_flag_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] timer_id_res_o;
  logic [4:0]  fired_count_o;
  logic [4:0]  occupancy_o;
  logic        last_o;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          quiet_phase = 1'b0;
  bit          long_hold = 1'b0;
  logic [15:0] used_ids[$];

  deadline_sorted_timer_table_core DUT (.*);

  dstt_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i, .timer_id_i,
    .duration_i, .repeat_req_i, .new_duration_flag_i, .out_valid_i(out_valid_o),
    .out_stall_i, .status_i(status_o), .timer_id_res_i(timer_id_res_o),
    .fired_count_i(fired_count_o), .occupancy_i(occupancy_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall results in random bursts, or hold off for a long stretch
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (600) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // Offer one command word and hold it until taken
  task automatic send_word(input cmd_e cmd, input logic [15:0] id, input logic [23:0] dur,
                           input logic rep, input logic nd);
    int n;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    timer_id_i <= id;
    duration_i <= dur;
    repeat_req_i <= rep;
    new_duration_flag_i <= nd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (cmd == CMD_ADD) used_ids.push_back(id);
  endtask

  function automatic logic [15:0] pick_id();
    if (used_ids.size() > 0 && $urandom_range(0, 3) != 0)
      return used_ids[$urandom_range(0, used_ids.size() - 1)];
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic release_word();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly short durations so timers fire; some large ones
  function automatic logic [23:0] pick_dur();
    case ($urandom_range(0, 9))
      0: return 24'($urandom());
      1: return 24'hFFFFFF;
      default: return 24'($urandom_range(0, 6));
    endcase
  endfunction

  initial begin
    cmd_e c;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table cases, extremes, zero-period repeat, duplicates
    send_word(CMD_TICK, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1);
    send_word(CMD_REMOVE, 16'h1234, 24'd0, 1'b0, 1'b0);
    send_word(CMD_RESET, 16'h1234, 24'd5, 1'b1, 1'b1);
    send_word(CMD_ADD, 16'h0000, 24'd0, 1'b1, 1'b0);
    send_word(CMD_ADD, 16'hFFFF, 24'hFFFFFF, 1'b0, 1'b1);
    send_word(CMD_ADD, 16'h00AA, 24'd1, 1'b0, 1'b0);
    send_word(CMD_ADD, 16'h00AA, 24'd1, 1'b1, 1'b0);
    send_word(CMD_TICK, 16'd0, 24'd0, 1'b0, 1'b0);
    send_word(CMD_TICK, 16'd0, 24'd0, 1'b0, 1'b0);
    send_word(CMD_RESET, 16'h00AA, 24'd3, 1'b0, 1'b1);
    send_word(CMD_RESET, 16'hFFFF, 24'd0, 1'b0, 1'b0);
    send_word(CMD_REMOVE, 16'h0000, 24'd0, 1'b0, 1'b0);
    for (int i = 0; i < 15; i++)
      send_word(CMD_ADD, 16'(i), 24'(i % 3), 1'(i), 1'b0);
    release_word();

    // Sender pauses until every result has come back
    while (pending != 0) @(posedge clk_i);

    // Full table refusal while the receiver holds off for a long stretch
    long_hold = 1'b1;
    for (int i = 0; i < 4; i++)
      send_word(CMD_ADD, 16'h5555, 24'd2, 1'b0, 1'b0);
    send_word(CMD_TICK, 16'd0, 24'd0, 1'b0, 1'b0);
    send_word(CMD_TICK, 16'd0, 24'd0, 1'b0, 1'b0);

    // Random commands, weighted toward ticks and adds
    for (int i = 0; i < 190; i++) begin
      if (i == 160) quiet_phase = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2: c = CMD_ADD;
        3: c = CMD_REMOVE;
        4: c = CMD_RESET;
        default: c = CMD_TICK;
      endcase
      send_word(c, pick_id(), pick_dur(), 1'($urandom()), 1'($urandom()));
    end
    release_word();

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> deadline_sorted_timer_table_core.f
rtl/dstt_pkg.sv
rtl/dstt_dp.sv
rtl/dstt_ctrl.sv
rtl/deadline_sorted_timer_table_core.sv
tb/dstt_checker.sv
tb/deadline_sorted_timer_table_core_tb.sv
